// ----- hw/rtl/srrip_pkg.sv -----
package srrip_pkg;

  // Operation codes carried in the func field of a request.
  localparam logic [1:0] FUNC_HIT   = 2'd0;
  localparam logic [1:0] FUNC_FILL  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Re-reference values.
  localparam logic [1:0] RRPV_MAX    = 2'd3;
  localparam logic [1:0] RRPV_HIT    = 2'd0;
  localparam logic [1:0] RRPV_INSERT = 2'd2;

  // Configuration register word index.
  localparam logic REG_INSERT_VALUE = 1'b0;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] set_index;
    logic [3:0] way;
  } req_item_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       victim_valid;
  } rsp_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_load;
    logic row_read;
    logic clear_write;
    logic finish;
  } srrip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } srrip_sts_t;

endpackage

// ----- hw/rtl/srrip_ram.sv -----
module srrip_ram import srrip_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hw/rtl/srrip_ctrl.sv -----
module srrip_ctrl import srrip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  srrip_sts_t sts,
  output srrip_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.item_load   = (state == ST_IDLE) && req_valid;
    cmd.row_read    = (state == ST_IDLE) && req_valid;
    cmd.clear_write = (state == ST_CLEAR);
    cmd.finish      = (state == ST_EXEC) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sts.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/srrip_dpath.sv -----
module srrip_dpath import srrip_pkg::*; #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  req_item_t  req,
  input  logic [1:0] insert_value,
  input  srrip_cmd_t cmd,
  output srrip_sts_t sts,
  output rsp_item_t  rsp
);

  localparam int ADDR_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ROW_W  = 2 * NUM_WAYS;

  typedef logic [NUM_WAYS-1:0][1:0] row_t;

  req_item_t         item;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  row_t              row;
  row_t              row_new;
  row_t              row_fill;
  logic [ROW_W-1:0]  ram_rdata;
  logic [1:0]        top;
  logic [1:0]        lift;
  logic              any_hi;
  logic              any_lo;
  logic              any_max;
  logic [3:0]        victim;
  logic              set_ok;
  logic              way_ok;
  logic              is_query;
  logic              is_touch;
  logic              need_write;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item <= req;
    end
  end

  // Row index sweep that sets every entry to the maximum value after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_write) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  assign sts.clear_last = (clr_cnt == ADDR_W'(NUM_SETS - 1));

  always_comb begin
    if (cmd.clear_write) begin
      ram_addr = clr_cnt;
    end else if (cmd.row_read) begin
      ram_addr = ADDR_W'(req.set_index);
    end else begin
      ram_addr = ADDR_W'(item.set_index);
    end
  end

  assign row      = row_t'(ram_rdata);
  assign set_ok   = (32'(item.set_index) < 32'(NUM_SETS));
  assign way_ok   = (32'(item.way) < 32'(NUM_WAYS));
  assign is_query = (item.func == FUNC_QUERY);
  assign is_touch = (item.func == FUNC_HIT) || (item.func == FUNC_FILL);

  // Largest value in the row, found bitwise across all ways at once.
  always_comb begin
    any_hi  = 1'b0;
    any_lo  = 1'b0;
    any_max = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any_hi  = any_hi | row[w][1];
      any_lo  = any_lo | row[w][0];
      any_max = any_max | (row[w] == RRPV_MAX);
    end
    top  = {any_hi, any_hi ? any_max : any_lo};
    lift = RRPV_MAX - top;
  end

  // The first way holding the largest value becomes the victim after aging.
  always_comb begin
    victim = 4'd0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row[w] == top) begin
        victim = 4'(w);
      end
    end
  end

  always_comb begin
    row_fill = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (32'(item.way) == w) begin
        row_fill[w] = (item.func == FUNC_HIT) ? RRPV_HIT : insert_value;
      end
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_new[w] = is_query ? (row[w] + lift) : row_fill[w];
    end
  end

  assign need_write = set_ok && (is_query || (is_touch && way_ok));
  assign ram_we     = cmd.clear_write || (cmd.finish && need_write);

  srrip_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.row_read),
    .addr  (ram_addr),
    .wdata (cmd.clear_write ? {ROW_W{1'b1}} : ROW_W'(row_new)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.victim_valid <= is_query && set_ok;
      rsp.victim_way   <= (is_query && set_ok) ? victim : 4'd0;
    end
  end

endmodule

// ----- hw/rtl/srrip_replacement_policy.sv -----
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_item_t (func, set_index, way)
// rsp       out        rsp_valid / rsp_stall   rsp_item_t (victim_way, victim_valid)
// apb       in         psel, penable, pready   insert_value at byte address 0
//
// Each transaction first reads the set's value row from the row memory, then
// computes the result and writes the updated row back.
// After reset a clearing pass writes every row to the maximum value, during
// which req_stall stays high; register writes still go in.
// The result sits in an output register; a stalled result only holds the block
// in its execute state until the consumer takes it.
module srrip_replacement_policy import srrip_pkg::*; #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_item_t   req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] insert_value;
  srrip_cmd_t cmd;
  srrip_sts_t sts;

  // The configuration port never waits.
  assign pready = 1'b1;

  // Only the insertion value is writable; its word index is paddr bit 2.
  always_ff @(posedge clk) begin
    if (rst) begin
      insert_value <= RRPV_INSERT;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_INSERT_VALUE)) begin
      insert_value <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_INSERT_VALUE) ? {30'd0, insert_value} : 32'd0;

  // The controller sequences the read, the update and the result handoff.
  srrip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath owns the row memory, the aging logic and the result register.
  srrip_dpath #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .insert_value (insert_value),
    .cmd          (cmd),
    .sts          (sts),
    .rsp          (rsp)
  );

`ifndef SYNTHESIS
  // A result that does not answer a query always carries way zero.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.victim_valid) |-> (rsp.victim_way == 4'd0))
    else $error("non-query result carries a nonzero way");

  // An accepted transaction blocks the next one from being taken right after it.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while the previous one is in flight");

  // Reset starts the clearing pass, so no request is taken right after it.
  assert property (@(posedge clk) rst |=> req_stall)
    else $error("request channel open right after reset");
`endif

endmodule

// ----- bench/srrip_victim_checker.sv -----
module srrip_victim_checker import srrip_pkg::*; #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_item_t   req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          results_checked,
  output int          queries_checked,
  output int          aged_queries
);

  localparam logic [2:0] INSERT_VALUE_ADDR = {REG_INSERT_VALUE, 2'b00};

  logic [1:0] shadow_rrpv [NUM_SETS][NUM_WAYS];
  logic [1:0] insert_rrpv;
  rsp_item_t  victim_queue [$];
  rsp_item_t  oldest;

  // Applies one transaction to the shadow table and returns the result it should produce.
  function automatic rsp_item_t predict_victim(input req_item_t r);
    rsp_item_t  res;
    logic [1:0] top;
    logic [1:0] lift;
    res = '0;
    if (r.set_index >= NUM_SETS) return res;
    case (r.func)
      FUNC_HIT: begin
        if (r.way < NUM_WAYS) shadow_rrpv[r.set_index][r.way] = RRPV_HIT;
      end
      FUNC_FILL: begin
        if (r.way < NUM_WAYS) shadow_rrpv[r.set_index][r.way] = insert_rrpv;
      end
      FUNC_QUERY: begin
        queries_checked++;
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (shadow_rrpv[r.set_index][w] > top) top = shadow_rrpv[r.set_index][w];
        end
        lift = RRPV_MAX - top;
        if (lift != 0) begin
          aged_queries++;
          for (int w = 0; w < NUM_WAYS; w++) begin
            shadow_rrpv[r.set_index][w] = shadow_rrpv[r.set_index][w] + lift;
          end
        end
        res.victim_valid = 1'b1;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
          if (shadow_rrpv[r.set_index][w] == RRPV_MAX) res.victim_way = 4'(w);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < NUM_WAYS; w++) shadow_rrpv[s][w] = RRPV_MAX;
      end
      insert_rrpv = RRPV_INSERT;
      victim_queue.delete();
    end else begin
      // Results are taken before new requests; a result never answers a request
      // accepted at the same edge.
      if (rsp_valid && !rsp_stall) begin
        if (victim_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, victim_way %0d victim_valid %0b", $time,
                   rsp.victim_way, rsp.victim_valid);
        end else begin
          oldest = victim_queue.pop_front();
          results_checked++;
          if (rsp.victim_way !== oldest.victim_way) begin
            errors++;
            $display("%0t: victim_way expected %0d actual %0d", $time,
                     oldest.victim_way, rsp.victim_way);
          end
          if (rsp.victim_valid !== oldest.victim_valid) begin
            errors++;
            $display("%0t: victim_valid expected %0b actual %0b", $time,
                     oldest.victim_valid, rsp.victim_valid);
          end
        end
      end
      if (req_valid && !req_stall) victim_queue.push_back(predict_victim(req));
      if (psel && penable && pready && paddr == INSERT_VALUE_ADDR) begin
        if (pwrite) begin
          insert_rrpv = pwdata[1:0];
        end else if (prdata[1:0] !== insert_rrpv) begin
          errors++;
          $display("%0t: insert_value readback expected %0d actual %0d", $time,
                   insert_rrpv, prdata[1:0]);
        end
      end
    end
    pending = victim_queue.size();
  end

endmodule

// ----- bench/tb_srrip_replacement_policy.sv -----
module tb_srrip_replacement_policy;
  import srrip_pkg::*;

  localparam int NUM_SETS = 64;
  localparam int NUM_WAYS = 16;

  // The func code left unused by the block; it must change nothing.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [2:0] INSERT_VALUE_ADDR = {REG_INSERT_VALUE, 2'b00};

  // Generous bound on the whole run, well above the slowest legal schedule.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the one long consumer hold-off that backs the block up.
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_item_t   req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_item_t   rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int results_checked;
  int queries_checked;
  int aged_queries;

  int cycle_count = 0;
  int burst_left = 0;
  int settings_used = 1;
  logic hold_off_arm = 1'b0;

  srrip_replacement_policy #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS)
  ) u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The checker watches both channels and the register port on its own; this
  // module only drives stimulus and reads back the tallies.
  srrip_victim_checker #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(errors), .pending(pending), .results_checked(results_checked),
    .queries_checked(queries_checked), .aged_queries(aged_queries)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_srrip_replacement_policy failed");
      $finish;
    end
  end

  // Consumer side. It switches between stall styles in stretches of random
  // length, including stretches with no stalls at all. Once armed, it also holds
  // off for a long run of cycles so the block's result register stays full and it
  // pushes back on the request channel.
  initial begin
    stall_mode_t mode;
    int mode_left;
    int hold_left;
    logic hold_done;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_arm && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  rsp_stall <= 1'b0;
          STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
          default:     rsp_stall <= ((mode_left % 5) < 2);
        endcase
      end
    end
  end

  function automatic req_item_t make_req(input logic [1:0] func, input logic [5:0] set_index,
                                         input logic [3:0] way);
    req_item_t r;
    r.func = func;
    r.set_index = set_index;
    r.way = way;
    return r;
  endfunction

  // Offers one transaction, starting at a falling edge. The sender works in
  // bursts; between bursts valid drops for a random gap, or not at all. Valid
  // stays high from one transaction to the next inside a burst.
  task automatic send_req(input req_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Most traffic lands on a small group of sets so rows fill up, age and get
  // re-referenced; the rest is spread over the whole cache.
  task automatic run_random(input int count, input logic [5:0] hot_base);
    req_item_t r;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) r.func = FUNC_HIT;
      else if (pick < 65) r.func = FUNC_FILL;
      else if (pick < 95) r.func = FUNC_QUERY;
      else r.func = FUNC_UNUSED;
      if ($urandom_range(0, 3) != 0) r.set_index = hot_base + 6'($urandom_range(0, 3));
      else r.set_index = 6'($urandom_range(0, NUM_SETS - 1));
      r.way = 4'($urandom_range(0, NUM_WAYS - 1));
      send_req(r);
    end
  endtask

  // Drops valid and waits until every transaction has come back.
  task automatic drain;
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  // One register transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic write, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic [1:0] insert_plan [4];
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    insert_plan[0] = 2'd3;
    insert_plan[1] = 2'd0;
    insert_plan[2] = 2'd1;
    insert_plan[3] = 2'($urandom_range(0, 3));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with insert_value still at its reset value.
    // A fresh set is all at the maximum, so the first way is the victim.
    send_req(make_req(FUNC_QUERY, 6'd0, 4'd0));
    // After a hit on way 0 the victim moves to way 1.
    send_req(make_req(FUNC_HIT, 6'd0, 4'd0));
    send_req(make_req(FUNC_QUERY, 6'd0, 4'd15));
    // The unused func code must leave the row alone.
    send_req(make_req(FUNC_UNUSED, 6'd0, 4'd1));
    send_req(make_req(FUNC_QUERY, 6'd0, 4'd0));
    // Fill ways 0 to 14 of the last set and hit way 15 so no way is at the maximum;
    // the query then has to age the whole row by one step before picking way 0.
    for (int i = 0; i < NUM_WAYS - 1; i++) send_req(make_req(FUNC_FILL, 6'd63, 4'(i)));
    send_req(make_req(FUNC_HIT, 6'd63, 4'd15));
    send_req(make_req(FUNC_QUERY, 6'd63, 4'd0));
    send_req(make_req(FUNC_HIT, 6'd63, 4'd0));
    send_req(make_req(FUNC_QUERY, 6'd63, 4'd0));

    run_random(100, 6'($urandom_range(0, NUM_SETS - 1)));

    // Each further phase runs under its own insertion value, the extremes first.
    for (int p = 0; p < 4; p++) begin
      drain();
      apb_access(1'b1, INSERT_VALUE_ADDR, {30'd0, insert_plan[p]});
      apb_access(1'b0, INSERT_VALUE_ADDR, '0);
      settings_used++;
      if (p == 1) hold_off_arm <= 1'b1;
      run_random(130, 6'($urandom_range(0, NUM_SETS - 1)));
    end

    drain();
    // Give a stray extra result time to show up.
    repeat (20) @(negedge clk);

    $display("Checked %0d transactions under %0d insertion values.", results_checked,
             settings_used);
    $display("%0d victim queries, %0d of which had to age their set.", queries_checked,
             aged_queries);
    if (errors == 0) begin
      $display("tb_srrip_replacement_policy passed");
    end else begin
      $display("%0d mismatches found", errors);
      $display("tb_srrip_replacement_policy failed");
    end
    $finish;
  end

endmodule

// ----- srrip_replacement_policy.f -----
hw/rtl/srrip_pkg.sv
hw/rtl/srrip_ram.sv
hw/rtl/srrip_ctrl.sv
hw/rtl/srrip_dpath.sv
hw/rtl/srrip_replacement_policy.sv
bench/srrip_victim_checker.sv
bench/tb_srrip_replacement_policy.sv
